>>> rtl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasterizer.
// No dependencies.
package mcr_pkg;

	localparam int McrQueueDepth = 2;

	// Decision increments of the midpoint walk
	localparam int StraightInc = 3;
	localparam int DiagonalInc = 5;

	localparam logic [2:0] LastPoint = 3'd7;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

	// One step's worth of work: offsets, center and the finish flag
	typedef struct packed {
		logic [7:0] off_x;
		logic [7:0] off_y;
		logic [7:0] mid_x;
		logic [7:0] mid_y;
		logic       fin;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> rtl/mcr_front.sv
// Front end: accepts load and step transactions, holds the walk state and
// queues one job per productive step. Depends on mcr_pkg.
module mcr_front import mcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] center_x,
	input  logic [7:0] center_y,
	input  logic [7:0] radius,
	input  q_status_t  q_status,
	output logic       push,
	output job_t       push_job
);

	logic [7:0]  off_x_q, off_y_q, mid_x_q, mid_y_q;
	logic [11:0] dec_q;
	logic        active_q;

	logic        accept, is_step, d_neg, fin;
	logic [9:0]  nx, ny;
	logic [11:0] dx2, dy2, dec_next;

	assign in_ready = !q_status.full;
	assign accept   = in_valid && in_ready;
	assign is_step  = (cmd == CMD_STEP);

	assign d_neg = dec_q[11];
	assign dx2   = {3'b000, off_x_q, 1'b0};
	assign dy2   = {3'b000, off_y_q, 1'b0};
	assign dec_next = d_neg ? dec_q + dx2 + 12'(StraightInc)
	                        : dec_q + dx2 - dy2 + 12'(DiagonalInc);
	assign nx  = {2'b00, off_x_q} + 10'd1;
	assign ny  = {2'b00, off_y_q} - {9'd0, !d_neg};
	assign fin = $signed(nx) > $signed(ny);

	assign push = accept && is_step && active_q;
	assign push_job = '{off_x: off_x_q, off_y: off_y_q, mid_x: mid_x_q,
	                    mid_y: mid_y_q, fin: fin};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q  <= '0;
			off_y_q  <= '0;
			mid_x_q  <= '0;
			mid_y_q  <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (!is_step) begin
				mid_x_q  <= center_x;
				mid_y_q  <= center_y;
				off_x_q  <= '0;
				off_y_q  <= radius;
				dec_q    <= 12'd1 - {4'd0, radius};
				active_q <= 1'b1;
			end else if (active_q) begin
				off_x_q  <= nx[7:0];
				off_y_q  <= ny[7:0];
				dec_q    <= dec_next;
				active_q <= !fin;
			end
		end
	end

endmodule

>>> rtl/mcr_queue.sv
// Small job FIFO between front and back end.
// Depends on mcr_pkg.
module mcr_queue import mcr_pkg::*; #(
	parameter int Depth = McrQueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      head,
	output q_status_t status
);

	localparam int PtrW = $clog2(Depth);
	localparam int CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

	job_t            mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign status.full  = (count_q == CntW'(Depth));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/mcr_back.sv
// Back end: expands one job into its eight octant points, one per cycle unless
// out_ready stalls, through a registered output stage. Depends on mcr_pkg.
module mcr_back import mcr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] point_x,
	output logic [7:0] point_y,
	output logic       last,
	output logic       finished
);

	job_t       job_q;
	logic       busy_q;
	logic [2:0] idx_q;
	logic       out_valid_q;
	logic       load_out, emit_last;
	logic [7:0] ax, ay;

	assign load_out  = !out_valid_q || out_ready;
	assign emit_last = busy_q && load_out && (idx_q == LastPoint);
	assign pop       = !q_status.empty && (!busy_q || emit_last);

	// Odd points swap the offsets; points 4..7 mirror x, points 2..5 mirror y
	assign ax = idx_q[0] ? job_q.off_y : job_q.off_x;
	assign ay = idx_q[0] ? job_q.off_x : job_q.off_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q && load_out) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == LastPoint) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (load_out) begin
			point_x  <= idx_q[2] ? job_q.mid_x - ax : job_q.mid_x + ax;
			point_y  <= (idx_q[1] ^ idx_q[2]) ? job_q.mid_y - ay : job_q.mid_y + ay;
			last     <= (idx_q == LastPoint);
			finished <= (idx_q == LastPoint) && job_q.fin;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/midpoint_circle_rasterizer_top.sv
// Midpoint circle rasterizer, top level: front end, job queue, back end.
// Depends on mcr_pkg, mcr_front, mcr_queue, mcr_back.
//
// A load transaction (cmd 0) produces no output. A step transaction (cmd 1)
// on a live circle produces eight points, one per cycle on the output port
// while out_ready is high. A new step is taken while the queue has room,
// before the points of the last one are out. A step's first point passes
// through the queue, the back end's job register and the registered output
// stage. Up to QueueDepth steps can wait in the queue while the output
// stalls, and loads are taken whenever the queue has room. A step on a
// finished or never loaded circle produces nothing.
module midpoint_circle_rasterizer_top import mcr_pkg::*; #(
	parameter int QueueDepth = McrQueueDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       cmd,
	input  logic [7:0] center_x,
	input  logic [7:0] center_y,
	input  logic [7:0] radius,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] point_x,
	output logic [7:0] point_y,
	output logic       last,
	output logic       finished
);

	logic      push, pop;
	job_t      push_job, head;
	q_status_t q_status;

	mcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.center_x (center_x),
		.center_y (center_y),
		.radius   (radius),
		.q_status (q_status),
		.push     (push),
		.push_job (push_job)
	);

	mcr_queue #(.Depth(QueueDepth)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	mcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.point_x   (point_x),
		.point_y   (point_y),
		.last      (last),
		.finished  (finished)
	);

	// finished only ever rides on the last point of a step
	a_fin_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !finished)
		else $error("finished without last");

	// points of one step leave back to back once the sink takes them
	a_step_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid)
		else $error("gap inside a step");

	a_queue_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_status.full && q_status.empty))
		else $error("queue both full and empty");

	// a pop is only issued against a non-empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty queue");

endmodule

>>> dv/tb.sv
// Testbench for midpoint_circle_rasterizer_top: directed table, then random circles.
// Depends on mcr_pkg, rasterizer RTL; checks every point against walker or typed row.
`timescale 1ns / 1ps

module tb import mcr_pkg::*;;

	localparam int RandomItems = 196;
	localparam int CycleLimit  = 200000;
	localparam int DrainCycles = 40;
	localparam int HoldCycles  = 300;
	localparam int TableRows   = 24;

	typedef struct packed {
		cmd_t       op;
		logic [7:0] cx;
		logic [7:0] cy;
		logic [7:0] rad;
		logic       typed;   // expectation given in the row instead of the walker
		logic [3:0] n_fixed;
		logic [7:0] fx;
		logic [7:0] fy;
		logic       ffin;
	} item_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
		logic       fin;
	} point_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       cmd;
	logic [7:0] center_x;
	logic [7:0] center_y;
	logic [7:0] radius;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] point_x;
	logic [7:0] point_y;
	logic       last;
	logic       finished;

	// walker state
	logic [7:0]        circ_x, circ_y;
	logic [7:0]        walk_x, walk_y;
	logic signed [11:0] walk_d;
	logic              circle_live;
	point_t            fresh_pts [8];

	point_t pending_points [$];
	item_t  sent_items [$];
	item_t  dir_table [TableRows];

	int accepted_cnt;
	int useful_items;
	int points_seen;
	int mismatches;
	int cycle_count;
	bit hold_off;
	bit calm;

	midpoint_circle_rasterizer_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .center_x(center_x), .center_y(center_y), .radius(radius),
		.out_valid(out_valid), .out_ready(out_ready),
		.point_x(point_x), .point_y(point_y), .last(last), .finished(finished)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("Regression FAIL");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at point %0d: got %0d, want %0d", what, points_seen, got, want);
		mismatches++;
	endtask

	// One transaction through the midpoint walk; fills fresh_pts and returns the count.
	task automatic trace_circle(input cmd_t op, input logic [7:0] cx, input logic [7:0] cy,
			input logic [7:0] rad, output int n);
		int         d, nx, ny;
		logic [7:0] ox, oy;
		logic       fin;
		n = 0;
		if (op == CMD_LOAD) begin
			circ_x = cx;
			circ_y = cy;
			walk_x = 8'd0;
			walk_y = rad;
			walk_d = 12'(1 - int'(rad));
			circle_live = 1'b1;
		end else if (circle_live) begin
			ox = walk_x;
			oy = walk_y;
			d  = int'(walk_d);
			nx = int'(ox) + 1;
			ny = int'(oy);
			if (d < 0) begin
				d += 2 * int'(ox) + StraightInc;
			end else begin
				d += 2 * (int'(ox) - int'(oy)) + DiagonalInc;
				ny -= 1;
			end
			fin = !(nx <= ny);
			fresh_pts[0] = '{circ_x + ox, circ_y + oy, 1'b0, 1'b0};
			fresh_pts[1] = '{circ_x + oy, circ_y + ox, 1'b0, 1'b0};
			fresh_pts[2] = '{circ_x + ox, circ_y - oy, 1'b0, 1'b0};
			fresh_pts[3] = '{circ_x + oy, circ_y - ox, 1'b0, 1'b0};
			fresh_pts[4] = '{circ_x - ox, circ_y - oy, 1'b0, 1'b0};
			fresh_pts[5] = '{circ_x - oy, circ_y - ox, 1'b0, 1'b0};
			fresh_pts[6] = '{circ_x - ox, circ_y + oy, 1'b0, 1'b0};
			fresh_pts[7] = '{circ_x - oy, circ_y + ox, 1'b1, fin};
			walk_d = 12'(d);
			walk_x = 8'(nx);
			walk_y = 8'(ny);
			circle_live = !fin;
			n = 8;
		end
	endtask

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		item_t  tag;
		point_t p;
		int     n;
		if (arst_n && in_valid && in_ready) begin
			tag = sent_items.pop_front();
			trace_circle(cmd_t'(cmd), center_x, center_y, radius, n);
			if (tag.typed) begin
				for (int i = 0; i < int'(tag.n_fixed); i++) begin
					p.x    = tag.fx;
					p.y    = tag.fy;
					p.last = (i == 7);
					p.fin  = (i == 7) && tag.ffin;
					pending_points.push_back(p);
				end
			end else begin
				for (int i = 0; i < n; i++)
					pending_points.push_back(fresh_pts[i]);
			end
			if (cmd_t'(cmd) == CMD_LOAD || n > 0)
				useful_items++;
			accepted_cnt++;
		end
	end

	// output side
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				report_mismatch("unexpected point_x", point_x, -1);
			end else begin
				want = pending_points.pop_front();
				if (point_x !== want.x)
					report_mismatch("point_x", point_x, want.x);
				if (point_y !== want.y)
					report_mismatch("point_y", point_y, want.y);
				if (last !== want.last)
					report_mismatch("last", last, want.last);
				if (finished !== want.fin)
					report_mismatch("finished", finished, want.fin);
			end
			points_seen++;
		end
	end

	// long stretch with no idling on either side
	always @(posedge clk) begin
		calm <= (useful_items >= 140) && (useful_items < 180);
	end

	// receiver holds off once so the queue fills and in_ready drops
	initial begin
		hold_off = 1'b0;
		wait (useful_items >= 60);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off)
				out_ready <= 1'b0;
			else if (calm)
				out_ready <= 1'b1;
			else
				out_ready <= ($urandom_range(0, 99) >= 29);
		end
	end

	task automatic offer(input item_t it);
		int seen;
		if (!calm) begin
			while ($urandom_range(0, 99) < 29) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		sent_items.push_back(it);
		in_valid <= 1'b1;
		cmd      <= it.op;
		center_x <= it.cx;
		center_y <= it.cy;
		radius   <= it.rad;
		seen = accepted_cnt;
		do @(negedge clk); while (accepted_cnt == seen);
	endtask

	function automatic item_t random_item(input cmd_t op, input logic [7:0] rad);
		item_t it;
		it = '0;
		it.op  = op;
		it.cx  = 8'($urandom_range(0, 255));
		it.cy  = 8'($urandom_range(0, 255));
		it.rad = rad;
		return it;
	endfunction

	initial begin
		int         item_goal;
		int         nsteps;
		int         sel;
		logic [7:0] rad;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_LOAD;
		center_x = 8'd0;
		center_y = 8'd0;
		radius = 8'd0;
		accepted_cnt = 0;
		useful_items = 0;
		points_seen = 0;
		mismatches = 0;
		cycle_count = 0;
		calm = 1'b0;
		circ_x = '0; circ_y = '0; walk_x = '0; walk_y = '0; walk_d = '0;
		circle_live = 1'b0;

		dir_table = '{
			// step with no circle loaded, then zero radius at both corners
			'{CMD_STEP, 8'hFF, 8'hFF, 8'hFF, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_LOAD, 8'h00, 8'h00, 8'h00, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b1, 4'd8, 8'h00, 8'h00, 1'b1},
			'{CMD_STEP, 8'h5A, 8'hA5, 8'h3C, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_LOAD, 8'hFF, 8'hFF, 8'h00, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b1, 4'd8, 8'hFF, 8'hFF, 1'b1},
			// radius one at the origin wraps below zero
			'{CMD_LOAD, 8'h00, 8'h00, 8'h01, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'hFF, 8'h00, 8'hFF, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_LOAD, 8'hFF, 8'h00, 8'h03, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			// largest radius
			'{CMD_LOAD, 8'h80, 8'h80, 8'hFF, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			// load while a circle is still live restarts the walk
			'{CMD_LOAD, 8'h00, 8'hFF, 8'h05, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_LOAD, 8'hAA, 8'h55, 8'hAA, 1'b1, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h55, 8'hAA, 8'h55, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0},
			'{CMD_STEP, 8'h00, 8'h00, 8'h00, 1'b0, 4'd0, 8'h00, 8'h00, 1'b0}
		};

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < TableRows; i++)
			offer(dir_table[i]);

		// random circles: mostly load then a run of steps, some noise in between
		item_goal = accepted_cnt + RandomItems;
		while (accepted_cnt < item_goal) begin
			if ($urandom_range(0, 99) < 85) begin
				sel = $urandom_range(0, 99);
				if (sel < 3)
					rad = 8'($urandom_range(0, 255));
				else if (sel < 20)
					rad = 8'($urandom_range(13, 60));
				else
					rad = 8'($urandom_range(0, 12));
				offer(random_item(CMD_LOAD, rad));
				nsteps = $urandom_range(1, int'(rad) - int'(rad) / 4 + 3);
				for (int k = 0; k < nsteps; k++) begin
					if (accepted_cnt >= item_goal)
						break;
					offer(random_item(CMD_STEP, 8'($urandom_range(0, 255))));
				end
			end else begin
				offer(random_item(cmd_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
			end
		end
		in_valid <= 1'b0;

		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
